// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/lqfs_pkg.sv =====
// Types and constants of the longest-queue-first server.
`default_nettype none
package lqfs_pkg;
   localparam int LQFS_QUEUE_DEPTH = 16;

   localparam int CODE_W   = 8;
   localparam int TAG_W    = 8;
   localparam int DUR_W    = 10;
   localparam int ENTRY_W  = TAG_W + DUR_W;
   localparam int BUDGET_W = 16;
   localparam int TOTAL_W  = 17;
   localparam int COUNT_W  = 6;
   localparam int AVG_W    = 18;
   localparam int DVD_W    = TOTAL_W + 8;

   localparam logic [CODE_W-1:0] CLASS_A_CHAR = 8'd83;
   localparam logic [CODE_W-1:0] CLASS_B_CHAR = 8'd70;
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd120;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_RUN     = 1'b1;

   localparam logic [1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [1:0] KIND_SERVED  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

   localparam logic CLASS_A = 1'b0;
   localparam logic CLASS_B = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [CODE_W-1:0] class_code;
      logic [TAG_W-1:0]  request_tag;
      logic [DUR_W-1:0]  duration;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [1:0]         enqueue_status;
      logic               served_class;
      logic [TAG_W-1:0]   served_tag;
      logic [DUR_W-1:0]   served_duration;
      logic [TOTAL_W-1:0] total_served_time;
      logic [COUNT_W-1:0] served_count;
      logic [AVG_W-1:0]   average_q8;
      logic               last_of_run;
   } rsp_payload_type;

   typedef logic [BUDGET_W-1:0] csr_payload_type;
endpackage
`default_nettype wire

// ===== sv/lqfs_chan_if.sv =====
// Valid/ready channel interface with a typed payload.
`default_nettype none
interface lqfs_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/lqfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lqfs_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== sv/lqfs_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the Q8 average.
`default_nettype none
`include "assert_macros.svh"
module lqfs_divider import lqfs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DVD_W-1:0]   dividend,
   input  wire logic [COUNT_W-1:0] divisor,
   output logic                    done,
   output logic      [AVG_W-1:0]   quotient
);
   localparam int STEP_W = $clog2(DVD_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DVD_W-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0] dsr_ff, dsr_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, shift_ff[DVD_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         step_in  = STEP_W'(DVD_W);
         shift_in = dividend;
         dsr_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         // quotient bits shift in from the right as dividend bits leave
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in   = COUNT_W'(trial - {1'b0, dsr_ff});
            shift_in = {shift_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in   = trial[COUNT_W-1:0];
            shift_in = {shift_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      dsr_ff   <= dsr_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff[AVG_W-1:0];

   `ASSERT_ALWAYS(a_busy_done_excl, clock, reset, !(busy_ff && done_ff))
   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff)
   `ASSERT_ALWAYS(a_step_zero_idle, clock, reset, busy_ff || step_ff == '0)
endmodule
`default_nettype wire

// ===== sv/longest_queue_first_server.sv =====
// Top level: two request FIFOs served longest-queue-first under a time budget.
//
//   channel   dir  payload            accept
//   req_chan  in   req_payload_type   valid && ready
//   rsp_chan  out  rsp_payload_type   valid && ready
//   csr_chan  in   session_budget     valid && ready (ready always high)
//
// Enqueue: its status item is registered in the output register.
// Run: each served entry takes a pick, then the FIFO RAM read; then a
// divider pass computes the average for the summary.
// req_chan.ready is low while a run is busy or an item waits in rsp_chan.
// A stalled rsp_chan holds the sequencer at its next pick or the summary.
// Synchronous reset empties both FIFOs; no clearing pass over the RAMs.
`default_nettype none
`include "assert_macros.svh"
module longest_queue_first_server import lqfs_pkg::*; #(
   parameter int QUEUE_DEPTH = LQFS_QUEUE_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   lqfs_chan_if.sink   req_chan,
   lqfs_chan_if.source rsp_chan,
   lqfs_chan_if.sink   csr_chan
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_PICK, S_READ, S_DIV} state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   a_head_ff, a_head_in, a_tail_ff, a_tail_in;
   logic [PTR_W-1:0]   b_head_ff, b_head_in, b_tail_ff, b_tail_in;
   logic [CNT_W-1:0]   a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               sel_b_ff, sel_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               a_wr_en, b_wr_en, a_rd_en, b_rd_en;
   logic [ENTRY_W-1:0] wr_entry, a_rd_data, b_rd_data, rd_entry;
   logic               div_start, div_done;
   logic [AVG_W-1:0]   div_quot;
   logic               req_fire, rsp_free;
   req_payload_type    req;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign req         = req_chan.data;
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign wr_entry    = {req.request_tag, req.duration};
   assign rd_entry    = sel_b_ff ? b_rd_data : a_rd_data;

   always_comb begin
      state_in     = state_ff;
      a_head_in    = a_head_ff;
      a_tail_in    = a_tail_ff;
      a_cnt_in     = a_cnt_ff;
      b_head_in    = b_head_ff;
      b_tail_in    = b_tail_ff;
      b_cnt_in     = b_cnt_ff;
      budget_in    = budget_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      sel_b_in     = sel_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      a_wr_en      = 1'b0;
      b_wr_en      = 1'b0;
      a_rd_en      = 1'b0;
      b_rd_en      = 1'b0;
      div_start    = 1'b0;

      if (csr_chan.valid) begin
         budget_in = csr_chan.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req.opcode == OP_ENQUEUE) begin
                  rsp_data_in             = '0;
                  rsp_data_in.result_kind = KIND_ENQUEUE;
                  rsp_data_in.last_of_run = 1'b1;
                  rsp_valid_in            = 1'b1;
                  if (req.class_code == CLASS_A_CHAR) begin
                     if (a_cnt_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        rsp_data_in.enqueue_status = STATUS_FULL;
                     end else begin
                        a_wr_en   = 1'b1;
                        a_tail_in = wrap_next(a_tail_ff);
                        a_cnt_in  = a_cnt_ff + CNT_W'(1);
                        rsp_data_in.enqueue_status = STATUS_ACCEPTED;
                     end
                  end else if (req.class_code == CLASS_B_CHAR) begin
                     if (b_cnt_ff >= CNT_W'(QUEUE_DEPTH)) begin
                        rsp_data_in.enqueue_status = STATUS_FULL;
                     end else begin
                        b_wr_en   = 1'b1;
                        b_tail_in = wrap_next(b_tail_ff);
                        b_cnt_in  = b_cnt_ff + CNT_W'(1);
                        rsp_data_in.enqueue_status = STATUS_ACCEPTED;
                     end
                  end else begin
                     rsp_data_in.enqueue_status = STATUS_UNKNOWN;
                  end
               end else begin
                  total_in = '0;
                  count_in = '0;
                  state_in = S_PICK;
               end
            end
         end
         S_PICK: begin
            if (rsp_free) begin
               if (total_ff >= TOTAL_W'(budget_ff) ||
                   (a_cnt_ff <= b_cnt_ff && b_cnt_ff == '0)) begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end else if (a_cnt_ff > b_cnt_ff) begin
                  a_rd_en   = 1'b1;
                  sel_b_in  = CLASS_A;
                  a_head_in = wrap_next(a_head_ff);
                  a_cnt_in  = a_cnt_ff - CNT_W'(1);
                  state_in  = S_READ;
               end else begin
                  b_rd_en   = 1'b1;
                  sel_b_in  = CLASS_B;
                  b_head_in = wrap_next(b_head_ff);
                  b_cnt_in  = b_cnt_ff - CNT_W'(1);
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            // output register is free here: the pick only moved on when it was
            rsp_data_in                 = '0;
            rsp_data_in.result_kind     = KIND_SERVED;
            rsp_data_in.served_class    = sel_b_ff;
            rsp_data_in.served_tag      = rd_entry[ENTRY_W-1:DUR_W];
            rsp_data_in.served_duration = rd_entry[DUR_W-1:0];
            rsp_valid_in                = 1'b1;
            total_in = total_ff + TOTAL_W'(rd_entry[DUR_W-1:0]);
            count_in = count_ff + COUNT_W'(1);
            state_in = S_PICK;
         end
         S_DIV: begin
            if (div_done && rsp_free) begin
               rsp_data_in                   = '0;
               rsp_data_in.result_kind       = KIND_SUMMARY;
               rsp_data_in.total_served_time = total_ff;
               rsp_data_in.served_count      = count_ff;
               rsp_data_in.average_q8        = (count_ff == '0) ? '0 : div_quot;
               rsp_data_in.last_of_run       = 1'b1;
               rsp_valid_in                  = 1'b1;
               state_in                      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_head_ff    <= '0;
         a_tail_ff    <= '0;
         a_cnt_ff     <= '0;
         b_head_ff    <= '0;
         b_tail_ff    <= '0;
         b_cnt_ff     <= '0;
         budget_ff    <= BUDGET_RESET;
         sel_b_ff     <= CLASS_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_head_ff    <= a_head_in;
         a_tail_ff    <= a_tail_in;
         a_cnt_ff     <= a_cnt_in;
         b_head_ff    <= b_head_in;
         b_tail_ff    <= b_tail_in;
         b_cnt_ff     <= b_cnt_in;
         budget_ff    <= budget_in;
         sel_b_ff     <= sel_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff    <= total_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   lqfs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_tail_ff),
      .wr_data (wr_entry),
      .rd_en   (a_rd_en),
      .rd_addr (a_head_ff),
      .rd_data (a_rd_data)
   );

   lqfs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_tail_ff),
      .wr_data (wr_entry),
      .rd_en   (b_rd_en),
      .rd_addr (b_head_ff),
      .rd_data (b_rd_data)
   );

   lqfs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({total_ff, 8'd0}),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   `ASSERT_ALWAYS(a_cnt_a_bound, clock, reset, a_cnt_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_cnt_b_bound, clock, reset, b_cnt_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_read_slot_free, clock, reset, state_ff != S_READ || !rsp_valid_ff)
   `ASSERT_NEXT(a_enq_result, clock, reset, req_fire && req.opcode == OP_ENQUEUE,
      rsp_valid_ff && state_ff == S_IDLE)
endmodule
`default_nettype wire

// ===== tb/sv/longest_queue_first_server_test.sv =====
// Self-checking testbench for the longest-queue-first server: random and directed items.
`timescale 1ns / 1ps
module longest_queue_first_server_test;
   import lqfs_pkg::*;

   localparam int IDLE_PCT      = 29;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int STEADY_FROM   = 500;
   localparam int STEADY_UNTIL  = 1500;

   typedef enum {STEP_ITEM, STEP_BUDGET, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type   kind;
      req_payload_type item;
      csr_payload_type budget;
   } plan_step_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [DUR_W-1:0] dur;
   } slot_type;

   logic clock;
   logic reset;

   lqfs_chan_if #(.payload_type(req_payload_type)) req_chan ();
   lqfs_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   lqfs_chan_if #(.payload_type(csr_payload_type)) csr_chan ();

   longest_queue_first_server DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   plan_step_type   plan [$];
   rsp_payload_type awaited_results [$];

   // predictor state: index 0 is class A, index 1 is class B
   slot_type        lane_store [2][LQFS_QUEUE_DEPTH];
   int unsigned     lane_head [2];
   int unsigned     lane_tail [2];
   int unsigned     lane_fill [2];
   csr_payload_type budget_now;

   int unsigned cycle_count = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;
   logic        steady;

   assign steady = cycle_count >= STEADY_FROM && cycle_count < STEADY_UNTIL;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned next_slot(int unsigned p);
      return (p + 1 >= LQFS_QUEUE_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic void forecast_service(req_payload_type it);
      rsp_payload_type   r;
      int                lane;
      int unsigned       total;
      int unsigned       served;
      slot_type          s;
      longint unsigned   avg;
      r = '0;
      if (it.opcode == OP_ENQUEUE) begin
         r.result_kind = KIND_ENQUEUE;
         r.last_of_run = 1'b1;
         if (it.class_code == CLASS_A_CHAR || it.class_code == CLASS_B_CHAR) begin
            lane = (it.class_code == CLASS_A_CHAR) ? 0 : 1;
            if (lane_fill[lane] >= LQFS_QUEUE_DEPTH) begin
               r.enqueue_status = STATUS_FULL;
            end else begin
               lane_store[lane][lane_tail[lane]] = {it.request_tag, it.duration};
               lane_tail[lane] = next_slot(lane_tail[lane]);
               lane_fill[lane]++;
               r.enqueue_status = STATUS_ACCEPTED;
            end
         end else begin
            r.enqueue_status = STATUS_UNKNOWN;
         end
         awaited_results.push_back(r);
      end else begin
         total = 0;
         served = 0;
         while (total < budget_now) begin
            // longer lane wins, a tie goes to B
            if (lane_fill[CLASS_A] > lane_fill[CLASS_B]) begin
               lane = 0;
            end else if (lane_fill[CLASS_B] == 0) begin
               break;
            end else begin
               lane = 1;
            end
            s = lane_store[lane][lane_head[lane]];
            lane_head[lane] = next_slot(lane_head[lane]);
            lane_fill[lane]--;
            total += s.dur;
            served++;
            r = '0;
            r.result_kind     = KIND_SERVED;
            r.served_class    = (lane == 0) ? CLASS_A : CLASS_B;
            r.served_tag      = s.tag;
            r.served_duration = s.dur;
            awaited_results.push_back(r);
         end
         avg = (served != 0) ? ((longint'(total) << 8) / served) : 0;
         r = '0;
         r.result_kind       = KIND_SUMMARY;
         r.total_served_time = TOTAL_W'(total);
         r.served_count      = COUNT_W'(served);
         r.average_q8        = AVG_W'(avg);
         r.last_of_run       = 1'b1;
         awaited_results.push_back(r);
      end
   endfunction

   function automatic string describe(rsp_payload_type r);
      return $sformatf({"kind=%0d status=%0d class=%0d tag=%0h dur=%0d",
                        " total=%0d count=%0d avg=%0d last=%0d"},
                       r.result_kind, r.enqueue_status, r.served_class, r.served_tag,
                       r.served_duration, r.total_served_time, r.served_count,
                       r.average_q8, r.last_of_run);
   endfunction

   task automatic push_item(logic op, logic [CODE_W-1:0] code, logic [TAG_W-1:0] tag,
                            logic [DUR_W-1:0] dur);
      plan_step_type s;
      s.kind = STEP_ITEM;
      s.item.opcode = op;
      s.item.class_code = code;
      s.item.request_tag = tag;
      s.item.duration = dur;
      s.budget = '0;
      plan.push_back(s);
   endtask

   task automatic push_budget(csr_payload_type value);
      plan_step_type s;
      s.kind = STEP_BUDGET;
      s.item = '0;
      s.budget = value;
      plan.push_back(s);
   endtask

   task automatic push_drain();
      plan_step_type s;
      s.kind = STEP_DRAIN;
      s.item = '0;
      s.budget = '0;
      plan.push_back(s);
   endtask

   function automatic logic [DUR_W-1:0] pick_duration();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5, 6: return DUR_W'($urandom_range(1, 60));
         default: return DUR_W'($urandom_range(1023));
      endcase
   endfunction

   // request and budget driver
   always @(posedge clock) begin : drive_requests
      logic          hold_req;
      logic          hold_csr;
      logic          send_req;
      logic          send_csr;
      logic          settled;
      plan_step_type head;
      int            k;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.data <= '0;
         csr_chan.valid <= 1'b0;
         csr_chan.data <= '0;
         budget_now = BUDGET_RESET;
         for (k = 0; k < 2; k++) begin
            lane_head[k] = 0;
            lane_tail[k] = 0;
            lane_fill[k] = 0;
         end
      end else begin
         if (req_chan.valid && req_chan.ready)
            forecast_service(req_chan.data);
         if (csr_chan.valid && csr_chan.ready)
            budget_now = csr_chan.data;
         hold_req = req_chan.valid && !req_chan.ready;
         hold_csr = csr_chan.valid && !csr_chan.ready;
         // same answer whichever block runs first at this edge
         settled = awaited_results.size() == 0 && !(rsp_chan.valid && rsp_chan.ready);
         send_req = 1'b0;
         send_csr = 1'b0;
         head = '{STEP_DRAIN, '0, '0};
         if (!hold_req && !hold_csr && plan.size() != 0) begin
            case (plan[0].kind)
               STEP_ITEM: begin
                  if (steady || $urandom_range(99) >= IDLE_PCT) begin
                     head = plan.pop_front();
                     send_req = 1'b1;
                  end
               end
               STEP_BUDGET: begin
                  if (settled) begin
                     head = plan.pop_front();
                     send_csr = 1'b1;
                  end
               end
               default: begin
                  if (settled)
                     head = plan.pop_front();
               end
            endcase
         end
         req_chan.valid <= hold_req || send_req;
         if (send_req)
            req_chan.data <= head.item;
         csr_chan.valid <= hold_csr || send_csr;
         if (send_csr)
            csr_chan.data <= head.budget;
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : watch_results
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d with nothing awaited: %s", results_seen, describe(got));
            end else begin
               want = awaited_results.pop_front();
               if (got.result_kind !== want.result_kind ||
                   got.enqueue_status !== want.enqueue_status ||
                   got.served_class !== want.served_class ||
                   got.served_tag !== want.served_tag ||
                   got.served_duration !== want.served_duration ||
                   got.total_served_time !== want.total_served_time ||
                   got.served_count !== want.served_count ||
                   got.average_q8 !== want.average_q8 ||
                   got.last_of_run !== want.last_of_run) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("result %0d expected %s", results_seen, describe(want));
                     $display("result %0d actual   %s", results_seen, describe(got));
                  end
               end
            end
            results_seen++;
         end
         rsp_chan.ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int                  i;
      int                  phase;
      int                  made;
      int                  pick;
      logic [CODE_W-1:0]   code;
      csr_payload_type     phase_budget [6];

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;

      // directed: unknown classes, empty run, full lane, zero budget, tie-break
      push_item(OP_ENQUEUE, 8'd0, 8'h00, 10'd0);
      push_item(OP_ENQUEUE, 8'd255, 8'hFF, 10'd1023);
      push_item(OP_ENQUEUE, CLASS_A_CHAR - 8'd1, 8'h3C, 10'd5);
      push_item(OP_RUN, 8'd0, 8'h00, 10'd0);
      push_budget(16'd0);
      for (i = 0; i < LQFS_QUEUE_DEPTH; i++)
         push_item(OP_ENQUEUE, CLASS_B_CHAR, TAG_W'(i * 17),
                   (i == 1) ? 10'd1023 : (i % 3 == 0) ? 10'd0 : DUR_W'(i * 60));
      push_item(OP_ENQUEUE, CLASS_B_CHAR, 8'hEE, 10'd44);
      push_item(OP_RUN, 8'hFF, 8'hFF, 10'd1023);
      push_budget(16'hFFFF);
      push_item(OP_RUN, 8'h55, 8'hAA, 10'h2AA);
      push_item(OP_ENQUEUE, CLASS_A_CHAR, 8'hA5, 10'd7);
      push_item(OP_ENQUEUE, CLASS_B_CHAR, 8'h5A, 10'd9);
      push_drain();
      push_item(OP_RUN, 8'd0, 8'h00, 10'd0);

      phase_budget[0] = BUDGET_W'($urandom_range(200, 2000));
      phase_budget[1] = 16'd0;
      phase_budget[2] = 16'hFFFF;
      phase_budget[3] = 16'd1;
      phase_budget[4] = BUDGET_W'($urandom_range(65535));
      phase_budget[5] = BUDGET_W'($urandom_range(20, 400));

      for (phase = 0; phase < 6; phase++) begin
         push_budget(phase_budget[phase]);
         made = 0;
         while (made < 63) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               // burst into one lane, enough to overflow it
               code = $urandom_range(1) ? CLASS_A_CHAR : CLASS_B_CHAR;
               repeat (LQFS_QUEUE_DEPTH + 1)
                  push_item(OP_ENQUEUE, code, TAG_W'($urandom), pick_duration());
               made += LQFS_QUEUE_DEPTH + 1;
            end else if (pick < 20) begin
               push_item(OP_RUN, CODE_W'($urandom), TAG_W'($urandom), DUR_W'($urandom));
               made++;
            end else if (pick < 26) begin
               push_item(OP_ENQUEUE, CODE_W'($urandom_range(255)), TAG_W'($urandom),
                         DUR_W'($urandom));
               made++;
            end else begin
               code = (pick < 63) ? CLASS_A_CHAR : CLASS_B_CHAR;
               push_item(OP_ENQUEUE, code, TAG_W'($urandom), pick_duration());
               made++;
            end
         end
         if (phase == 2)
            push_drain();
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (plan.size() != 0 || req_chan.valid || csr_chan.valid ||
             awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/lqfs_pkg.sv
sv/lqfs_chan_if.sv
sv/lqfs_ram.sv
sv/lqfs_divider.sv
sv/longest_queue_first_server.sv
tb/sv/longest_queue_first_server_test.sv
